@@ rtl/core/rlse_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rlse_pkg
// Shared sizes, token, operator and status codes, and the operator function
// of the postfix logic stack evaluator.
// ----------------------------------------------------------------------------
package rlse_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int DATA_W      = 32;

	typedef logic [1:0] kind_t;
	typedef logic [2:0] func_t;
	typedef logic [1:0] status_t;

	localparam kind_t KIND_NUMBER   = 2'd0;
	localparam kind_t KIND_OPERATOR = 2'd1;
	localparam kind_t KIND_END      = 2'd2;

	localparam func_t FUNC_AND = 3'd0;
	localparam func_t FUNC_OR  = 3'd1;
	localparam func_t FUNC_EQ  = 3'd2;
	localparam func_t FUNC_NE  = 3'd3;
	localparam func_t FUNC_GT  = 3'd4;
	localparam func_t FUNC_LT  = 3'd5;
	localparam func_t FUNC_GE  = 3'd6;
	localparam func_t FUNC_LE  = 3'd7;

	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_FEW      = 2'd1;
	localparam status_t ST_COUNT    = 2'd2;
	localparam status_t ST_OVERFLOW = 2'd3;

	// Result of lhs OP rhs; the comparisons are signed.
	function automatic logic apply_func(input logic [DATA_W-1:0] lhs,
		input logic [DATA_W-1:0] rhs, input func_t f);
		logic res;
		unique case (f)
			FUNC_AND: res = (lhs != '0) && (rhs != '0);
			FUNC_OR:  res = (lhs != '0) || (rhs != '0);
			FUNC_EQ:  res = (lhs == rhs);
			FUNC_NE:  res = (lhs != rhs);
			FUNC_GT:  res = ($signed(lhs) >  $signed(rhs));
			FUNC_LT:  res = ($signed(lhs) <  $signed(rhs));
			FUNC_GE:  res = ($signed(lhs) >= $signed(rhs));
			FUNC_LE:  res = ($signed(lhs) <= $signed(rhs));
			default:  res = 1'b0;
		endcase
		return res;
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/rpn_logic_stack_evaluator_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_logic_stack_evaluator_core
// Postfix logic evaluator: pushes numbers, applies logic and signed compare
// operators on a RAM-held operand stack, and reports truth and status at end.
// ----------------------------------------------------------------------------
// Throughput: one token per cycle; in_ready drops only while an end token
// waits behind a result that has not yet been taken.
// Path: an end token's result passes the stage-2 register and then the
// output register. Stack read at acceptance, write-back in the next cycle.
// Reset: arst_n clears the stack pointer, error latch and valid flags at
// once; the stack memory is not cleared, only entries below the pointer
// are ever used.
module rpn_logic_stack_evaluator_core import rlse_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [1:0]               token_kind,
	input  wire logic signed [DATA_W-1:0] number,
	input  wire logic [2:0]               func,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic                          truth,
	output logic [1:0]                    status
);

	localparam logic [SP_W-1:0] SP_FULL = SP_W'(STACK_DEPTH);

	logic            accept;
	logic [SP_W-1:0] sp_q, sp_d, sp_m1, sp_m2;
	status_t         err_q, err_d;

	logic            push_s1, op_s1, fin_s1;
	status_t         status_s1;
	logic [ADDR_W-1:0] raddr_r, raddr_l, waddr_s1;

	logic            s2_valid_q;
	logic            push_s2, op_s2, fin_s2;
	func_t           func_s2;
	logic [DATA_W-1:0] num_s2;
	logic [ADDR_W-1:0] waddr_s2;
	status_t         status_s2;
	logic            byp_r_s2, byp_l_s2;
	logic [DATA_W-1:0] byp_data_s2;

	logic [DATA_W-1:0] rdata_r, rdata_l, rhs, lhs, wdata;
	logic            wr_en, s2_done, out_load, truth_d;
	logic            out_valid_q, truth_q;
	status_t         status_q;

	assign accept = in_valid && in_ready;
	assign sp_m1  = sp_q - SP_W'(1);
	assign sp_m2  = sp_q - SP_W'(2);
	assign raddr_r = sp_m1[ADDR_W-1:0];
	assign raddr_l = sp_m2[ADDR_W-1:0];
	assign waddr_s1 = push_s1 ? sp_q[ADDR_W-1:0] : sp_m2[ADDR_W-1:0];

	// Pointer and error bookkeeping depends only on token kinds, so it is
	// settled at acceptance; data work follows one stage later.
	always_comb begin
		sp_d      = sp_q;
		err_d     = err_q;
		push_s1   = 1'b0;
		op_s1     = 1'b0;
		fin_s1    = 1'b0;
		status_s1 = ST_OK;
		unique case (token_kind)
			KIND_NUMBER: begin
				if (err_q == ST_OK) begin
					if (sp_q >= SP_FULL) begin
						err_d = ST_OVERFLOW;
					end else begin
						push_s1 = 1'b1;
						sp_d    = sp_q + SP_W'(1);
					end
				end
			end
			KIND_OPERATOR: begin
				if (err_q == ST_OK) begin
					if (sp_q < SP_W'(2)) begin
						err_d = ST_FEW;
					end else begin
						op_s1 = 1'b1;
						sp_d  = sp_m1;
					end
				end
			end
			KIND_END: begin
				fin_s1 = 1'b1;
				sp_d   = '0;
				err_d  = ST_OK;
				if (err_q != ST_OK) begin
					status_s1 = err_q;
				end else if (sp_q != SP_W'(1)) begin
					status_s1 = ST_COUNT;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q  <= '0;
			err_q <= ST_OK;
		end else if (accept) begin
			sp_q  <= sp_d;
			err_q <= err_d;
		end
	end

	// Two mirrored copies give the two read ports that an operator needs.
	rlse_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_ram_r (
		.clk   (clk),
		.we    (wr_en),
		.waddr (waddr_s2),
		.wdata (wdata),
		.re    (accept),
		.raddr (raddr_r),
		.rdata (rdata_r)
	);

	rlse_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_ram_l (
		.clk   (clk),
		.we    (wr_en),
		.waddr (waddr_s2),
		.wdata (wdata),
		.re    (accept),
		.raddr (raddr_l),
		.rdata (rdata_l)
	);

	// Stage 2: operands arrive from the RAM, or from the bypass when the
	// previous word wrote the same entry in the cycle of the read.
	assign rhs     = byp_r_s2 ? byp_data_s2 : rdata_r;
	assign lhs     = byp_l_s2 ? byp_data_s2 : rdata_l;
	assign wdata   = push_s2 ? num_s2 : DATA_W'(apply_func(lhs, rhs, func_s2));
	assign wr_en   = s2_valid_q && (push_s2 || op_s2);
	assign truth_d = (status_s2 == ST_OK) && (rhs != '0);

	assign s2_done  = s2_valid_q && (!fin_s2 || !out_valid_q || out_ready);
	assign in_ready = !s2_valid_q || s2_done;
	assign out_load = s2_valid_q && fin_s2 && s2_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (accept) begin
			s2_valid_q <= 1'b1;
		end else if (s2_done) begin
			s2_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			push_s2     <= push_s1;
			op_s2       <= op_s1;
			fin_s2      <= fin_s1;
			func_s2     <= func;
			num_s2      <= number;
			waddr_s2    <= waddr_s1;
			status_s2   <= status_s1;
			byp_r_s2    <= wr_en && (waddr_s2 == raddr_r);
			byp_l_s2    <= wr_en && (waddr_s2 == raddr_l);
			byp_data_s2 <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			truth_q  <= truth_d;
			status_q <= status_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign truth     = truth_q;
	assign status    = status_q;

endmodule
`default_nettype wire

@@ rtl/core/rlse_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rlse_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rlse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/rlse_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rlse_checker
// Port-level checks of the postfix logic evaluator, bound to its top level.
// ----------------------------------------------------------------------------
module rlse_checker import rlse_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic [1:0]        token_kind,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic              truth,
	input wire logic [1:0]        status
);

	// A result word that is not taken stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(truth) && $stable(status))
		else $error("result word changed or dropped while stalled");

	a_err_truth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> !truth)
		else $error("truth set on an error status");

	// A fresh result must come from an end token accepted earlier.
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && (token_kind == KIND_END), 2))
		else $error("result word without a preceding end token");

	// Input is only held off by a waiting result.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with an empty output");

endmodule

bind rpn_logic_stack_evaluator_core rlse_checker u_rlse_checker (.*);
`default_nettype wire

@@ verif/rpn_logic_stack_evaluator_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rpn_logic_stack_evaluator_core_tb
// Drives postfix token streams into the evaluator, predicts each end-token
// verdict from a private copy of the stack, pointer and error latch, and
// checks truth and status of every word that leaves the block.
// ----------------------------------------------------------------------------
module rpn_logic_stack_evaluator_core_tb;
	import rlse_pkg::*;

	localparam kind_t KIND_UNUSED = 2'd3;
	localparam logic [DATA_W-1:0] INT_MIN = 32'h8000_0000;
	localparam logic [DATA_W-1:0] INT_MAX = 32'h7fff_ffff;

	typedef struct {
		logic    truth;
		status_t status;
	} verdict_t;

	class expression_tracker;
		logic [DATA_W-1:0] stk [STACK_DEPTH];
		int                depth;
		status_t           err;
		verdict_t          pending_verdicts [$];
		int                errors;

		function new();
			depth  = 0;
			err    = ST_OK;
			errors = 0;
		endfunction

		function int pending();
			return pending_verdicts.size();
		endfunction

		// Applies one accepted token word to the tracked stack.
		function void note_token(kind_t k, logic [DATA_W-1:0] n, func_t f);
			logic signed [DATA_W-1:0] lhs;
			logic signed [DATA_W-1:0] rhs;
			logic                     res;
			verdict_t                 v;
			case (k)
				KIND_NUMBER: begin
					if (err == ST_OK) begin
						if (depth >= STACK_DEPTH) begin
							err = ST_OVERFLOW;
						end else begin
							stk[depth] = n;
							depth++;
						end
					end
				end
				KIND_OPERATOR: begin
					if (err == ST_OK) begin
						if (depth < 2) begin
							err = ST_FEW;
						end else begin
							rhs = stk[depth-1];
							lhs = stk[depth-2];
							case (f)
								FUNC_AND: res = (lhs != 0) && (rhs != 0);
								FUNC_OR:  res = (lhs != 0) || (rhs != 0);
								FUNC_EQ:  res = (lhs == rhs);
								FUNC_NE:  res = (lhs != rhs);
								FUNC_GT:  res = (lhs > rhs);
								FUNC_LT:  res = (lhs < rhs);
								FUNC_GE:  res = (lhs >= rhs);
								default:  res = (lhs <= rhs);
							endcase
							stk[depth-2] = {{(DATA_W-1){1'b0}}, res};
							depth--;
						end
					end
				end
				KIND_END: begin
					v.status = err;
					if (err == ST_OK && depth != 1)
						v.status = ST_COUNT;
					v.truth = (v.status == ST_OK) && (stk[0] != 0);
					pending_verdicts = {pending_verdicts, v};
					depth = 0;
					err   = ST_OK;
				end
				default: ;
			endcase
		endfunction

		function void check_verdict(logic t, logic [1:0] s);
			verdict_t v;
			if (pending_verdicts.size() == 0) begin
				$display("%0t: unexpected result word, truth %0d status %0d", $time, t, s);
				errors++;
				return;
			end
			v = pending_verdicts.pop_front();
			if (s !== v.status) begin
				$display("%0t: status expected %0d got %0d", $time, v.status, s);
				errors++;
			end
			if (t !== v.truth) begin
				$display("%0t: truth expected %0d got %0d", $time, v.truth, t);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [1:0]        token_kind;
	logic [DATA_W-1:0] number;
	logic [2:0]        func;
	logic              out_valid;
	logic              out_ready;
	logic              truth;
	logic [1:0]        status;

	expression_tracker tracker = new();
	bit                quiet;
	bit                rx_hold_req;
	int                words_sent;

	rpn_logic_stack_evaluator_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.token_kind(token_kind),
		.number(number),
		.func(func),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.truth(truth),
		.status(status)
	);

	always #6 clk = ~clk;

	// Mostly back to back, some short gaps, a few long ones.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	function automatic logic [DATA_W-1:0] pick_number();
		int r;
		int v;
		r = $urandom_range(0, 9);
		if (r < 5) begin
			v = int'($urandom_range(0, 6)) - 3;
			return v;
		end
		if (r == 5)
			return INT_MIN;
		if (r == 6)
			return INT_MAX;
		if (r == 7)
			return '0;
		return $urandom;
	endfunction

	task automatic send_token(kind_t k, logic [DATA_W-1:0] n, func_t f);
		int gap;
		token_kind <= k;
		number     <= n;
		func       <= f;
		in_valid   <= 1'b1;
		do
			@(posedge clk);
		while (!(in_valid && in_ready === 1'b1));
		tracker.note_token(k, n, f);
		if (k != KIND_UNUSED)
			words_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_push(logic [DATA_W-1:0] n);
		send_token(KIND_NUMBER, n, func_t'($urandom_range(0, 7)));
	endtask

	task automatic send_op(func_t f);
		send_token(KIND_OPERATOR, $urandom, f);
	endtask

	task automatic send_end();
		send_token(KIND_END, $urandom, func_t'($urandom_range(0, 7)));
	endtask

	// Well-formed postfix expression over the given number of operands.
	task automatic send_expression(int operands);
		int depth;
		int left;
		depth = 0;
		left  = operands;
		while (left > 0 || depth > 1) begin
			if (depth >= 2 && (left == 0 || $urandom_range(0, 2) == 0)) begin
				send_op(func_t'($urandom_range(0, 7)));
				depth--;
			end else begin
				send_push(pick_number());
				depth++;
				left--;
			end
		end
		send_end();
	endtask

	// Receiver: accepts result words and stalls at random.
	initial begin
		int stall_cnt;
		stall_cnt = 0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready)
				tracker.check_verdict(truth, status);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				stall_cnt   = 80;
			end else if (stall_cnt == 0 && $urandom_range(0, 3) == 0) begin
				stall_cnt = pick_gap();
			end
			if (stall_cnt > 0) begin
				out_ready <= 1'b0;
				stall_cnt--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		#5_000_000;
		$display("rpn_logic_stack_evaluator_core verification failed");
		$finish;
	end

	initial begin
		int r;
		int n;
		int target;
		clk         = 1'b0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		token_kind  = KIND_NUMBER;
		number      = '0;
		func        = FUNC_AND;
		out_ready   = 1'b0;
		quiet       = 1'b0;
		rx_hold_req = 1'b0;
		words_sent  = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// An empty expression reports a wrong final count.
		send_end();
		// One chain through every operator, with the extreme operands.
		send_push(INT_MIN);
		send_push(INT_MAX);
		send_op(FUNC_GT);
		send_push(32'hffff_ffff);
		send_op(FUNC_LT);
		send_push('0);
		send_op(FUNC_EQ);
		send_push(32'd1);
		send_op(FUNC_NE);
		send_push(INT_MIN);
		send_op(FUNC_GE);
		send_push(INT_MAX);
		send_op(FUNC_LE);
		send_push('0);
		send_op(FUNC_AND);
		send_push(32'hffff_ffff);
		send_op(FUNC_OR);
		send_end();
		// Operator on a single entry; the push after it must be ignored.
		send_push(32'd7);
		send_op(FUNC_OR);
		send_push(32'd9);
		send_end();

		target = words_sent + 400;
		n = 0;
		while (words_sent < target) begin
			n++;
			quiet = (n >= 20 && n < 35);
			if (n == 45) begin
				// Hold the receiver off while end tokens keep coming.
				quiet       = 1'b1;
				rx_hold_req = 1'b1;
				repeat (12) begin
					send_push(pick_number());
					send_end();
				end
				quiet = 1'b0;
			end
			r = $urandom_range(0, 99);
			if (r < 70) begin
				if ($urandom_range(0, 99) < 85)
					send_expression($urandom_range(1, 5));
				else
					send_expression($urandom_range(6, STACK_DEPTH));
			end else if (r < 78) begin
				repeat ($urandom_range(STACK_DEPTH + 1, STACK_DEPTH + 3))
					send_push(pick_number());
				repeat ($urandom_range(0, 2))
					send_op(func_t'($urandom_range(0, 7)));
				send_end();
			end else begin
				// Random junk, including the unused token kind.
				repeat ($urandom_range(0, 12)) begin
					case ($urandom_range(0, 3))
						0, 1:    send_push(pick_number());
						2:       send_op(func_t'($urandom_range(0, 7)));
						default: send_token(KIND_UNUSED, $urandom,
							func_t'($urandom_range(0, 7)));
					endcase
				end
				send_end();
			end
		end
		in_valid <= 1'b0;

		while (tracker.pending() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (tracker.errors == 0)
			$display("rpn_logic_stack_evaluator_core verification clean");
		else
			$display("rpn_logic_stack_evaluator_core verification failed");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/rlse_pkg.sv
rtl/core/rlse_ram.sv
rtl/core/rpn_logic_stack_evaluator_core.sv
rtl/core/rlse_checker.sv
verif/rpn_logic_stack_evaluator_core_tb.sv
